@@ design/rbe_pkg.sv @@
// Shared constants for the ray / box entry point block.
package rbe_pkg;

	// Quotient bits resolved per divider pipeline stage
	localparam int DIV_STEP = 4;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

	// Hit axis codes
	localparam logic [1:0] HIT_AXIS_Z = 2'd0;
	localparam logic [1:0] HIT_AXIS_Y = 2'd1;
	localparam logic [1:0] HIT_AXIS_X = 2'd2;

	// Face sign codes
	localparam logic [1:0] FACE_NONE = 2'b00;
	localparam logic [1:0] FACE_POS  = 2'b01;
	localparam logic [1:0] FACE_NEG  = 2'b11;

endpackage

@@ design/ray_box_entry_point.sv @@
// Top level of the ray / axis-aligned box entry point block.
//
// Usage:
//  - Load the box through the configuration channel (cfg_valid/cfg_ready,
//    cfg_index, cfg_data). cfg_ready is always high, so every beat is
//    taken. Indexes above five are dropped. Write only while no ray is in
//    flight.
//  - Present a ray on origin_* / dir_* with start high. busy stays low, so a
//    ray is taken in every cycle that start is high; one ray per cycle is
//    the sustained rate.
//  - Each ray yields exactly one result: done pulses for one cycle with hit,
//    hit_axis, face_sign and point_* valid. Most of the pipeline depth lies in
//    the six pipelined dividers, which resolve four quotient bits per stage.
//  - Pipeline: register the ray and pick the face planes, form the six
//    magnitude products, divide, add origins and test the faces, then pick
//    the z, y, x winner into the output registers.
//  - The receiver cannot hold off results, so the pipeline never stalls.
//  - Reset clears the box registers to zero and drops all rays in flight.
module ray_box_entry_point import rbe_pkg::*; #(
	parameter int COORD_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_BITS-1:0]  origin_x,
	input  logic signed [COORD_BITS-1:0]  origin_y,
	input  logic signed [COORD_BITS-1:0]  origin_z,
	input  logic signed [COORD_BITS-1:0]  dir_x,
	input  logic signed [COORD_BITS-1:0]  dir_y,
	input  logic signed [COORD_BITS-1:0]  dir_z,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [COORD_BITS-1:0]         cfg_data,
	output logic                          done,
	output logic                          hit,
	output logic [1:0]                    hit_axis,
	output logic signed [1:0]             face_sign,
	output logic signed [COORD_BITS-1:0]  point_x,
	output logic signed [COORD_BITS-1:0]  point_y,
	output logic signed [COORD_BITS-1:0]  point_z
);

	localparam int C       = COORD_BITS;
	localparam int C2      = 2 * COORD_BITS;
	localparam int NST     = (COORD_BITS + DIV_STEP - 1) / DIV_STEP;
	localparam int DIV_LAT = NST + 2;

	// Box registers
	logic [C-1:0] box_min_x_q, box_min_y_q, box_min_z_q;
	logic [C-1:0] box_max_x_q, box_max_y_q, box_max_z_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_x_q <= '0;
			box_min_y_q <= '0;
			box_min_z_q <= '0;
			box_max_x_q <= '0;
			box_max_y_q <= '0;
			box_max_z_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_BOX_MIN_X: box_min_x_q <= cfg_data;
				REG_BOX_MIN_Y: box_min_y_q <= cfg_data;
				REG_BOX_MIN_Z: box_min_z_q <= cfg_data;
				REG_BOX_MAX_X: box_max_x_q <= cfg_data;
				REG_BOX_MAX_Y: box_max_y_q <= cfg_data;
				REG_BOX_MAX_Z: box_max_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Per-axis views, index 0 x, 1 y, 2 z
	logic [C-1:0] box_lo [3];
	logic [C-1:0] box_hi [3];
	logic [C-1:0] org    [3];
	logic [C-1:0] dir    [3];

	assign box_lo[0] = box_min_x_q;
	assign box_lo[1] = box_min_y_q;
	assign box_lo[2] = box_min_z_q;
	assign box_hi[0] = box_max_x_q;
	assign box_hi[1] = box_max_y_q;
	assign box_hi[2] = box_max_z_q;
	assign org[0]    = origin_x;
	assign org[1]    = origin_y;
	assign org[2]    = origin_z;
	assign dir[0]    = dir_x;
	assign dir[1]    = dir_y;
	assign dir[2]    = dir_z;

	logic accept;
	assign accept = start & ~busy;

	// Stage 1: pick the face plane per axis and take magnitudes
	logic [C-1:0] plane_c [3];
	logic [C:0]   diff_c  [3];

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			plane_c[a] = dir[a][C-1] ? box_hi[a] : box_lo[a];
			diff_c[a]  = {plane_c[a][C-1], plane_c[a]} - {org[a][C-1], org[a]};
		end
	end

	logic         v_s1;
	logic [C-1:0] o_s1     [3];
	logic [C-1:0] plane_s1 [3];
	logic [C-1:0] dmag_s1  [3];
	logic [C:0]   dfmag_s1 [3];
	logic         dneg_s1  [3];
	logic         dnz_s1   [3];
	logic         dfneg_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			o_s1[a]     <= org[a];
			plane_s1[a] <= plane_c[a];
			dneg_s1[a]  <= dir[a][C-1];
			dnz_s1[a]   <= |dir[a];
			dmag_s1[a]  <= dir[a][C-1] ? -dir[a] : dir[a];
			dfneg_s1[a] <= diff_c[a][C];
			dfmag_s1[a] <= diff_c[a][C] ? -diff_c[a] : diff_c[a];
		end
	end

	// Stage 2: six projection products, two per axis
	logic         v_s2;
	logic [C-1:0] o_s2     [3];
	logic [C-1:0] plane_s2 [3];
	logic         dneg_s2  [3];
	logic         dnz_s2   [3];
	logic [C2-1:0] prod_s2 [6];
	logic [C-1:0]  den_s2  [6];
	logic          pneg_s2 [6];
	logic [C-1:0]  quo     [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		o_s2     <= o_s1;
		plane_s2 <= plane_s1;
		dneg_s2  <= dneg_s1;
		dnz_s2   <= dnz_s1;
	end

	// Projection j tests axis j/2; the other coordinate is the lower then the upper one
	for (genvar j = 0; j < 6; j++) begin : g_proj
		localparam int A = j / 2;
		localparam int K = (j % 2 == 0) ? ((A == 0) ? 1 : 0) : ((A == 2) ? 1 : 2);

		logic [C2-1:0] prod_c;

		// Diff magnitude is one bit wider than the direction: add its top bit apart
		assign prod_c = C2'(dmag_s1[K]) * C2'(dfmag_s1[A][C-1:0])
			+ (dfmag_s1[A][C] ? {dmag_s1[K], {C{1'b0}}} : {C2{1'b0}});

		always_ff @(posedge clk) begin
			prod_s2[j] <= prod_c;
			den_s2[j]  <= dmag_s1[A];
			pneg_s2[j] <= dneg_s1[K] ^ dfneg_s1[A] ^ dneg_s1[A];
		end

		rbe_div #(.W(C)) u_div (
			.clk (clk),
			.num (prod_s2[j]),
			.den (den_s2[j]),
			.neg (pneg_s2[j]),
			.quo (quo[j])
		);
	end

	// Hold the ray sideband alongside the dividers
	logic [DIV_LAT-1:0] vld_dly_q;
	logic [C-1:0] o_dly_q     [DIV_LAT][3];
	logic [C-1:0] plane_dly_q [DIV_LAT][3];
	logic         dneg_dly_q  [DIV_LAT][3];
	logic         dnz_dly_q   [DIV_LAT][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_dly_q <= '0;
		end else begin
			vld_dly_q <= {vld_dly_q[DIV_LAT-2:0], v_s2};
		end
	end

	always_ff @(posedge clk) begin
		o_dly_q[0]     <= o_s2;
		plane_dly_q[0] <= plane_s2;
		dneg_dly_q[0]  <= dneg_s2;
		dnz_dly_q[0]   <= dnz_s2;
		for (int i = 1; i < DIV_LAT; i++) begin
			o_dly_q[i]     <= o_dly_q[i-1];
			plane_dly_q[i] <= plane_dly_q[i-1];
			dneg_dly_q[i]  <= dneg_dly_q[i-1];
			dnz_dly_q[i]   <= dnz_dly_q[i-1];
		end
	end

	// Stage 3: add origins and test strictly inside the face
	logic         v_s3;
	logic [C-1:0] plane_s3 [3];
	logic         dneg_s3  [3];
	logic         dnz_s3   [3];
	logic         in_s3    [6];
	logic [C-1:0] pt_s3    [6];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= vld_dly_q[DIV_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		plane_s3 <= plane_dly_q[DIV_LAT-1];
		dneg_s3  <= dneg_dly_q[DIV_LAT-1];
		dnz_s3   <= dnz_dly_q[DIV_LAT-1];
	end

	for (genvar j = 0; j < 6; j++) begin : g_test
		localparam int A = j / 2;
		localparam int K = (j % 2 == 0) ? ((A == 0) ? 1 : 0) : ((A == 2) ? 1 : 2);

		logic [C:0] p_c;
		logic       in_c;

		// A sum out of range lands outside the box and is never taken
		assign p_c = {quo[j][C-1], quo[j]}
			+ {o_dly_q[DIV_LAT-1][K][C-1], o_dly_q[DIV_LAT-1][K]};
		assign in_c = ($signed({box_lo[K][C-1], box_lo[K]}) < $signed(p_c))
			&& ($signed(p_c) < $signed({box_hi[K][C-1], box_hi[K]}));

		always_ff @(posedge clk) begin
			in_s3[j] <= in_c;
			pt_s3[j] <= p_c[C-1:0];
		end
	end

	// Stage 4: z faces win over y, y over x
	logic         ok_x, ok_y, ok_z;
	logic         hit_c;
	logic [1:0]   axis_c;
	logic [1:0]   face_c;
	logic [C-1:0] px_c, py_c, pz_c;

	assign ok_x = dnz_s3[0] & in_s3[0] & in_s3[1];
	assign ok_y = dnz_s3[1] & in_s3[2] & in_s3[3];
	assign ok_z = dnz_s3[2] & in_s3[4] & in_s3[5];

	always_comb begin
		hit_c  = 1'b0;
		axis_c = HIT_AXIS_Z;
		px_c   = '0;
		py_c   = '0;
		pz_c   = '0;
		// On a miss the face comes from the first axis with a nonzero direction: x, then y, then z
		if (dnz_s3[0]) begin
			face_c = dneg_s3[0] ? FACE_NEG : FACE_POS;
		end else if (dnz_s3[1]) begin
			face_c = dneg_s3[1] ? FACE_NEG : FACE_POS;
		end else if (dnz_s3[2]) begin
			face_c = dneg_s3[2] ? FACE_NEG : FACE_POS;
		end else begin
			face_c = FACE_NONE;
		end
		if (ok_z) begin
			hit_c  = 1'b1;
			axis_c = HIT_AXIS_Z;
			face_c = dneg_s3[2] ? FACE_NEG : FACE_POS;
			px_c   = pt_s3[4];
			py_c   = pt_s3[5];
			pz_c   = plane_s3[2];
		end else if (ok_y) begin
			hit_c  = 1'b1;
			axis_c = HIT_AXIS_Y;
			face_c = dneg_s3[1] ? FACE_NEG : FACE_POS;
			px_c   = pt_s3[2];
			py_c   = plane_s3[1];
			pz_c   = pt_s3[3];
		end else if (ok_x) begin
			hit_c  = 1'b1;
			axis_c = HIT_AXIS_X;
			face_c = dneg_s3[0] ? FACE_NEG : FACE_POS;
			px_c   = plane_s3[0];
			py_c   = pt_s3[0];
			pz_c   = pt_s3[1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit       <= hit_c;
		hit_axis  <= axis_c;
		face_sign <= face_c;
		point_x   <= px_c;
		point_y   <= py_c;
		point_z   <= pz_c;
	end

endmodule

@@ design/rbe_div.sv @@
// Pipelined restoring divider with signed saturation of the quotient.
module rbe_div import rbe_pkg::*; #(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic [2*W-1:0]      num,
	input  logic [W-1:0]        den,
	input  logic                neg,
	output logic signed [W-1:0] quo
);

	localparam int NST = (W + DIV_STEP - 1) / DIV_STEP;

	logic [W-1:0] rem_s [NST+1];
	logic [W-1:0] qb_s  [NST+1];
	logic [W-1:0] low_s [NST+1];
	logic [W-1:0] den_s [NST+1];
	logic         neg_s [NST+1];
	logic         ovf_s [NST+1];

	// Entry: quotient overflows W bits when the high half reaches the divisor
	always_ff @(posedge clk) begin
		rem_s[0] <= num[2*W-1:W];
		low_s[0] <= num[W-1:0];
		den_s[0] <= den;
		neg_s[0] <= neg;
		ovf_s[0] <= (num[2*W-1:W] >= den);
		qb_s[0]  <= '0;
	end

	for (genvar j = 0; j < NST; j++) begin : g_stage
		logic [W-1:0] rem_n;
		logic [W-1:0] qb_n;

		always_comb begin
			logic [W:0] t;
			logic [W-1:0] r;
			logic [W-1:0] q;
			r = rem_s[j];
			q = qb_s[j];
			t = '0;
			for (int s = 0; s < DIV_STEP; s++) begin
				if (j * DIV_STEP + s < W) begin
					t = {r, low_s[j][W-1-(j*DIV_STEP+s)]};
					if (t >= {1'b0, den_s[j]}) begin
						t = t - {1'b0, den_s[j]};
						q[W-1-(j*DIV_STEP+s)] = 1'b1;
					end
					r = t[W-1:0];
				end
			end
			rem_n = r;
			qb_n  = q;
		end

		always_ff @(posedge clk) begin
			rem_s[j+1] <= rem_n;
			qb_s[j+1]  <= qb_n;
			low_s[j+1] <= low_s[j];
			den_s[j+1] <= den_s[j];
			neg_s[j+1] <= neg_s[j];
			ovf_s[j+1] <= ovf_s[j];
		end
	end

	logic [W-1:0] lim;
	logic [W-1:0] mag;

	always_comb begin
		lim = neg_s[NST] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		mag = (ovf_s[NST] || (qb_s[NST] > lim)) ? lim : qb_s[NST];
	end

	always_ff @(posedge clk) begin
		quo <= neg_s[NST] ? -mag : mag;
	end

endmodule
